/* sv/ssd_pkg.sv */
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int unsigned DigitsDef  = 4;
  localparam int unsigned StoreDepth = 4;
  localparam int unsigned SegW       = 8;
  localparam int unsigned SelW       = 8;
  localparam int unsigned WordW      = SegW + SelW;
  localparam int unsigned CntW       = $clog2(WordW + 1);

  localparam logic [SegW-1:0] GlyphDegree = 8'h9C;
  localparam logic [SegW-1:0] GlyphC      = 8'hC6;

  // Saturation limits per request kind
  localparam logic [13:0] NumberMax = 14'd9999;
  localparam logic [13:0] DegreeMax = 14'd999;
  localparam logic [13:0] TempMax   = 14'd99;
  localparam logic [6:0]  ClockMax  = 7'd99;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_NUMBER = 3'd1,
    REQ_TIME   = 3'd2,
    REQ_TEMP   = 3'd3,
    REQ_DEGREE = 3'd4,
    REQ_DIGITS = 3'd5,
    REQ_RAW    = 3'd6
  } req_e;

  typedef logic [SegW-1:0] seg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [13:0] number;
    logic [6:0]  hours;
    logic [6:0]  minutes;
    logic [7:0]  code1;
    logic [7:0]  code2;
    logic [7:0]  code3;
    logic [7:0]  code4;
  } in_item_t;

  typedef struct packed {
    logic serial_bit;
    logic latch_after;
  } out_item_t;

  // Decoded set request: load flag and the four segment codes, first digit at index 0
  typedef struct packed {
    logic                        load;
    seg_t [StoreDepth-1:0]       segs;
  } dec_t;

  // Word handed to the shifter
  typedef struct packed {
    logic             load;
    logic [WordW-1:0] word;
  } ser_load_t;

  // Active-low glyph of a decimal digit; anything above nine shows as nine
  function automatic seg_t glyph(input logic [7:0] d);
    seg_t g;
    case (d)
      8'd0:    g = 8'hC0;
      8'd1:    g = 8'hF9;
      8'd2:    g = 8'hA4;
      8'd3:    g = 8'hB0;
      8'd4:    g = 8'h99;
      8'd5:    g = 8'h92;
      8'd6:    g = 8'h82;
      8'd7:    g = 8'hF8;
      8'd8:    g = 8'h80;
      default: g = 8'h90;
    endcase
    return g;
  endfunction

endpackage

/* sv/ssd_decode.sv */
`timescale 1ns / 1ps

module ssd_decode import ssd_pkg::*; (
  input  in_item_t item_i,
  output dec_t     dec_o
);

  logic [13:0] lim;
  logic [13:0] num_sat;
  logic [29:0] p10;
  logic [26:0] p100;
  logic [27:0] p1000;
  logic [9:0]  q10;
  logic [6:0]  q100;
  logic [3:0]  q1000;
  logic [13:0] t10;
  logic [9:0]  t100;
  logic [6:0]  t1000;
  logic [3:0]  d0, d1, d2, d3;
  logic [6:0]  hr_sat, mn_sat;
  logic [14:0] ph, pm;
  logic [3:0]  ht, hu, mt, mu;
  logic [6:0]  ht10, mt10;

  // Saturate the number per request kind
  always_comb begin
    unique case (item_i.req_type)
      REQ_TEMP:   lim = TempMax;
      REQ_DEGREE: lim = DegreeMax;
      default:    lim = NumberMax;
    endcase
    num_sat = (item_i.number > lim) ? lim : item_i.number;
  end

  // Reciprocal multiply, exact for values up to 9999
  assign p10   = {16'd0, num_sat} * 30'd52429;
  assign p100  = {13'd0, num_sat} * 27'd5243;
  assign p1000 = {14'd0, num_sat} * 28'd8389;
  assign q10   = p10[28:19];
  assign q100  = p100[25:19];
  assign q1000 = p1000[26:23];

  assign t10   = 14'({q10, 3'b000}) + 14'({q10, 1'b0});
  assign t100  = 10'({q100, 3'b000}) + 10'({q100, 1'b0});
  assign t1000 = 7'({q1000, 3'b000}) + 7'({q1000, 1'b0});
  assign d0    = 4'(num_sat - t10);
  assign d1    = 4'(q10 - t100);
  assign d2    = 4'(q100 - t1000);
  assign d3    = q1000;

  // Time digits, exact for values up to 99
  assign hr_sat = (item_i.hours > ClockMax) ? ClockMax : item_i.hours;
  assign mn_sat = (item_i.minutes > ClockMax) ? ClockMax : item_i.minutes;
  assign ph     = {8'd0, hr_sat} * 15'd205;
  assign pm     = {8'd0, mn_sat} * 15'd205;
  assign ht     = ph[14:11];
  assign mt     = pm[14:11];
  assign ht10   = 7'({ht, 3'b000}) + 7'({ht, 1'b0});
  assign mt10   = 7'({mt, 3'b000}) + 7'({mt, 1'b0});
  assign hu     = 4'(hr_sat - ht10);
  assign mu     = 4'(mn_sat - mt10);

  always_comb begin
    dec_o.load = 1'b1;
    dec_o.segs = '0;
    unique case (item_i.req_type)
      REQ_NUMBER: begin
        dec_o.segs[0] = glyph({4'd0, d3});
        dec_o.segs[1] = glyph({4'd0, d2});
        dec_o.segs[2] = glyph({4'd0, d1});
        dec_o.segs[3] = glyph({4'd0, d0});
      end
      REQ_TIME: begin
        dec_o.segs[0] = glyph({4'd0, ht});
        dec_o.segs[1] = glyph({4'd0, hu});
        dec_o.segs[2] = glyph({4'd0, mt});
        dec_o.segs[3] = glyph({4'd0, mu});
      end
      REQ_TEMP: begin
        dec_o.segs[0] = glyph({4'd0, d1});
        dec_o.segs[1] = glyph({4'd0, d0});
        dec_o.segs[2] = GlyphDegree;
        dec_o.segs[3] = GlyphC;
      end
      REQ_DEGREE: begin
        dec_o.segs[0] = glyph({4'd0, d2});
        dec_o.segs[1] = glyph({4'd0, d1});
        dec_o.segs[2] = glyph({4'd0, d0});
        dec_o.segs[3] = GlyphDegree;
      end
      REQ_DIGITS: begin
        dec_o.segs[0] = glyph(item_i.code1);
        dec_o.segs[1] = glyph(item_i.code2);
        dec_o.segs[2] = glyph(item_i.code3);
        dec_o.segs[3] = glyph(item_i.code4);
      end
      REQ_RAW: begin
        dec_o.segs[0] = item_i.code1;
        dec_o.segs[1] = item_i.code2;
        dec_o.segs[2] = item_i.code3;
        dec_o.segs[3] = item_i.code4;
      end
      default: begin
        dec_o.load = 1'b0;
      end
    endcase
  end

endmodule

/* sv/ssd_serializer.sv */
`timescale 1ns / 1ps

module ssd_serializer import ssd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ser_load_t load_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] word_q, word_d;
  logic             take;

  assign out_valid_o            = (cnt_q != '0);
  assign take                   = out_valid_o && out_ready_i;
  assign out_item_o.serial_bit  = word_q[WordW-1];
  assign out_item_o.latch_after = (cnt_q == CntW'(1));
  // Free now, or the last bit leaves this cycle
  assign ready_o                = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_ready_i);

  always_comb begin
    cnt_d  = cnt_q;
    word_d = word_q;
    if (load_i.load) begin
      cnt_d  = CntW'(WordW);
      word_d = load_i.word;
    end else if (take) begin
      cnt_d  = cnt_q - CntW'(1);
      word_d = {word_q[WordW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

/* sv/seven_segment_scan_driver_top.sv */
`timescale 1ns / 1ps
// Flow: a word is registered on acceptance and handled from there; a tick waits until the
// shifter is free, which registers its word and sends one bit per accepted output cycle.
// Throughput: one set request per cycle while no tick waits; the 16-bit shifter takes a new
// tick as its last bit goes. Any tick, blank slot too, holds the input until the shifter frees.
// Reset: scan slot, all segment codes and the shifter bit count clear to zero.

module seven_segment_scan_driver_top import ssd_pkg::*; #(
  parameter int unsigned DIGITS = DigitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // Slot runs 0 after reset, then 1..DIGITS+1; the last value is the blank slot
  localparam int unsigned SlotW = $clog2(DIGITS + 2);

  logic                  s1_valid_q;
  in_item_t              s1_item_q;
  logic [SlotW-1:0]      slot_q;
  seg_t [StoreDepth-1:0] seg_q;

  dec_t             dec;
  ser_load_t        ser_load;
  logic             ser_ready;
  logic             is_tick;
  logic             s1_fire;
  logic [SlotW-1:0] slot_next;
  logic             show;
  logic [2:0]       idx;
  seg_t             seg_sel;
  logic [SelW-1:0]  sel;

  // Front stage: hold one word; it moves on when handled, so the input stays open
  // while a previous tick is still being shifted out.
  assign is_tick    = (s1_item_q.req_type == REQ_TICK);
  assign s1_fire    = s1_valid_q && (!is_tick || ser_ready);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
  end

  // Turn set requests into four segment codes
  ssd_decode u_decode (
    .item_i (s1_item_q),
    .dec_o  (dec)
  );

  // Advance the scan slot; wrap from the blank slot back to the first digit
  assign slot_next = (slot_q <= SlotW'(DIGITS)) ? slot_q + SlotW'(1) : SlotW'(1);
  assign show      = (slot_next <= SlotW'(DIGITS));
  assign idx       = 3'(slot_next - SlotW'(1));

  // Digits past the four loaded ones show as code zero
  assign seg_sel = (idx < 3'(StoreDepth)) ? seg_q[idx[1:0]] : '0;
  assign sel     = SelW'(1) << idx;

  assign ser_load.load = s1_fire && is_tick && show;
  assign ser_load.word = {seg_sel, sel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      seg_q  <= '0;
    end else if (s1_fire) begin
      if (is_tick) begin
        slot_q <= slot_next;
      end
      if (dec.load) begin
        seg_q <= dec.segs;
      end
    end
  end

  // Shift out segment code then select byte, MSB first; flag the latch on the last bit
  ssd_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ser_load),
    .ready_o     (ser_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
